// ----- src/tsamp_pkg.sv -----
package tsamp_pkg;

  localparam int LOGIT_W   = 16;
  localparam int TEMP_W    = 16;
  localparam int TOPK_W    = 7;
  localparam int TOPP_W    = 17;
  localparam int MINP_W    = 16;
  localparam int DRAW_W    = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 17;

  // exp unit: Q1.16 result, Q30 factors
  localparam int EXP_W     = 17;
  localparam int Q30_W     = 31;
  localparam int EXP_N_W   = 25;
  localparam int EXP_FLUSH = 4096;
  localparam int A_DEPTH   = 17;
  localparam int A_IDX_W   = 5;
  localparam int F_DEPTH   = 256;

  // divider for the tempered exponent
  localparam int DVD_W     = 25;
  localparam int DVS_W     = 16;
  localparam int DCNT_W    = 5;

  // wide enough to compare counts up to 256
  localparam int KC_W      = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_K       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_P       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_P       = 8'd3;

  typedef logic [Q30_W-1:0] ftab_t [F_DEPTH];
  typedef logic [Q30_W-1:0] atab_t [A_DEPTH];

  // shift and subtract quotient, elaboration only
  function automatic longint unsigned udiv64(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int bi = 63; bi >= 0; bi--) begin
      r = {r[62:0], a[bi]};
      if (r >= b) begin
        r     = r - b;
        q[bi] = 1'b1;
      end
    end
    return q;
  endfunction

  // alternating series for exp(-num/den) in Q30, elaboration only
  function automatic longint unsigned neg_series(input longint unsigned num,
                                                 input longint unsigned den);
    longint sum;
    longint unsigned term;
    sum  = 0;
    term = 64'd1 << 30;
    for (int i = 0; i < 64; i++) begin
      if (term != 0) begin
        if (i[0] == 1'b0) sum = sum + longint'(term);
        else sum = sum - longint'(term);
        term = udiv64(term * num, den * longint'(i + 1));
      end
    end
    if (sum < 0) sum = 0;
    return longint'(sum);
  endfunction

  function automatic ftab_t build_f();
    ftab_t t;
    for (int f = 0; f < F_DEPTH; f++) begin
      t[f] = Q30_W'(neg_series(longint'(f), 64'd256));
    end
    return t;
  endfunction

  function automatic atab_t build_a();
    atab_t t;
    longint unsigned x;
    longint unsigned e1;
    e1 = neg_series(64'd1, 64'd1);
    x  = 64'd1 << 30;
    t[0] = Q30_W'(x);
    for (int a = 1; a < A_DEPTH; a++) begin
      x = (x * e1 + (64'd1 << 29)) >> 30;
      t[a] = Q30_W'(x);
    end
    return t;
  endfunction

  localparam ftab_t F_TAB = build_f();
  localparam atab_t A_TAB = build_a();

endpackage

// ----- src/tsamp_exp.sv -----
module tsamp_exp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tsamp_pkg::EXP_N_W-1:0] n,
  output logic                         valid,
  output logic [tsamp_pkg::EXP_W-1:0]   e
);
  import tsamp_pkg::*;

  logic                 flush;
  logic [A_IDX_W-1:0]   a_idx;
  logic [Q30_W-1:0]     a_r;
  logic [Q30_W-1:0]     f_r;
  logic                 fl_r;
  logic                 v1_r;
  logic                 v2_r;
  logic [EXP_W-1:0]     e_r;
  logic [2*Q30_W-1:0]   prod;
  logic [2*Q30_W-1:0]   rnd;

  assign flush = n > EXP_N_W'(EXP_FLUSH);
  assign a_idx = flush ? '0 : n[8+A_IDX_W-1:8];

  // integer part times fraction part, rounded to Q1.16
  assign prod = (2*Q30_W)'(a_r) * (2*Q30_W)'(f_r);
  assign rnd  = prod + ((2*Q30_W)'(1) << 43);

  always_ff @(posedge clk) begin
    a_r <= A_TAB[a_idx];
    f_r <= F_TAB[n[7:0]];
    fl_r <= flush;
    e_r <= fl_r ? '0 : rnd[44+EXP_W-1:44];
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  assign valid = v2_r;
  assign e     = e_r;

endmodule

// ----- src/tsamp_div.sv -----
module tsamp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tsamp_pkg::DVD_W-1:0] dividend,
  input  logic [tsamp_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [tsamp_pkg::DVD_W-1:0] quotient
);
  import tsamp_pkg::*;

  logic [DVS_W-1:0]  rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [DVS_W:0]    sh;
  logic [DVS_W:0]    diff;
  logic              ge;

  // restoring division, one quotient bit a cycle
  assign sh   = {rem_r, quo_r[DVD_W-1]};
  assign ge   = sh >= {1'b0, dvs_r};
  assign diff = sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- src/token_sampler_topk_topp_minp_top.sv -----
// non-last logit: into an empty list at once, else a read and a compare per entry it passes
// last logit: insert, then untempered weights, top-p and min-p cuts, tempered weights and draw
// flow: one transaction at a time, in_ready only while the sequencer is idle
// the shared exp pipe and the bit-serial divider set the post-processing length
// reset (synchronous, active low) clears list count, id counter and result valid; no
// clearing pass, candidate storage is undefined until written
module token_sampler_topk_topp_minp_top #(
  parameter int MAX_CAND  = 64,
  parameter int MAX_VOCAB = 262144,
  localparam int CNT_W = $clog2(MAX_CAND + 1),
  localparam int ID_W  = $clog2(MAX_VOCAB)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [tsamp_pkg::LOGIT_W-1:0]   in_logit,
  input  logic                                   in_last,
  input  logic [tsamp_pkg::DRAW_W-1:0]           in_draw,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ID_W-1:0]                        out_token_id,
  output logic [CNT_W-1:0]                       out_kept_count,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tsamp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tsamp_pkg::CFG_DAT_W-1:0]        cfg_data
);
  import tsamp_pkg::*;

  localparam int AW    = $clog2(MAX_CAND);
  localparam int SUM_W = EXP_W + $clog2(MAX_CAND);
  localparam int PT_W  = SUM_W + TOPP_W;

  typedef enum logic [4:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_PUT,
    S_HEAD_RD, S_HEAD,
    S_U_RD, S_U_EXP, S_U_WAIT,
    S_P_INIT, S_P_RD, S_P_CHK,
    S_M_INIT, S_M_RD, S_M_CHK,
    S_W_INIT, S_W_RD, S_W_DIV, S_W_DWAIT, S_W_EWAIT,
    S_D_INIT, S_D_RD, S_D_CHK,
    S_SEL_RD, S_SEL, S_OUT
  } state_t;

  // configuration registers
  logic [TEMP_W-1:0] temp_r;
  logic [TOPK_W-1:0] topk_r;
  logic [TOPP_W-1:0] topp_r;
  logic [MINP_W-1:0] minp_r;

  // sequencer state
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ID_W-1:0]      nidx_r, nidx_nxt;
  logic signed [LOGIT_W-1:0] l_r, l_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic                 last_r, last_nxt;
  logic [DRAW_W-1:0]    draw_r, draw_nxt;
  logic [AW-1:0]        w_r, w_nxt;
  logic                 full_r, full_nxt;
  logic signed [LOGIT_W-1:0] maxl_r, maxl_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic [CNT_W-1:0]     i_r, i_nxt;
  logic [AW-1:0]        sel_r, sel_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [SUM_W-1:0]     cum_r, cum_nxt;
  logic [PT_W-1:0]      pthr_r, pthr_nxt;
  logic [SUM_W-1:0]     tgt_r, tgt_nxt;
  logic [ID_W-1:0]      res_tok_r, res_tok_nxt;
  logic [CNT_W-1:0]     res_kept_r, res_kept_nxt;
  logic                 ov_r, ov_nxt;
  logic [ID_W-1:0]      out_tok_r, out_tok_nxt;
  logic [CNT_W-1:0]     out_kept_r, out_kept_nxt;

  // candidate list memories, shared write and read addresses
  logic signed [LOGIT_W-1:0] cand_logit_mem [MAX_CAND];
  logic [ID_W-1:0]      cand_index_mem [MAX_CAND];
  logic                 cand_we;
  logic [AW-1:0]        cand_waddr;
  logic signed [LOGIT_W-1:0] cand_wl;
  logic [ID_W-1:0]      cand_wid;
  logic [AW-1:0]        cand_raddr;
  logic signed [LOGIT_W-1:0] rd_logit_r;
  logic [ID_W-1:0]      rd_index_r;

  // weight memory: untempered weights first, tempered ones after the cuts
  logic [EXP_W-1:0]     wt_mem [MAX_CAND];
  logic                 wt_we;
  logic [EXP_W-1:0]     wt_wdata;
  logic [EXP_W-1:0]     wt_rdata_r;

  // shared units
  logic                 exp_start;
  logic [EXP_N_W-1:0]   exp_n;
  logic                 exp_valid;
  logic [EXP_W-1:0]     exp_e;
  logic                 div_start;
  logic [DVD_W-1:0]     div_dvd;
  logic                 div_done;
  logic [DVD_W-1:0]     div_quo;

  logic [LOGIT_W:0]     diff;
  logic [KC_W-1:0]      klim;
  logic [SUM_W-1:0]     cumn;
  logic [SUM_W+DRAW_W-1:0] tprod;

  tsamp_exp u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (exp_start),
    .n     (exp_n),
    .valid (exp_valid),
    .e     (exp_e)
  );

  tsamp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (temp_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ready       = state_r == S_IDLE;
  assign cfg_ready      = 1'b1;
  assign out_valid      = ov_r;
  assign out_token_id   = out_tok_r;
  assign out_kept_count = out_kept_r;

  // distance from the top logit, never negative
  assign diff  = {maxl_r[LOGIT_W-1], maxl_r} - {rd_logit_r[LOGIT_W-1], rd_logit_r};
  assign klim  = (topk_r == '0) ? KC_W'(MAX_CAND) : KC_W'(topk_r);
  assign cumn  = cum_r + SUM_W'(wt_rdata_r);
  assign tprod = (SUM_W+DRAW_W)'(draw_r) * (SUM_W+DRAW_W)'(sum_r);

  // config write transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r <= TEMP_W'(256);
      topk_r <= '0;
      topp_r <= TOPP_W'(65536);
      minp_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TEMPERATURE: temp_r <= cfg_data[TEMP_W-1:0];
        CFG_TOP_K:       topk_r <= cfg_data[TOPK_W-1:0];
        CFG_TOP_P:       topp_r <= cfg_data[TOPP_W-1:0];
        CFG_MIN_P:       minp_r <= cfg_data[MINP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cand_we) begin
      cand_logit_mem[cand_waddr] <= cand_wl;
      cand_index_mem[cand_waddr] <= cand_wid;
    end
    rd_logit_r <= cand_logit_mem[cand_raddr];
    rd_index_r <= cand_index_mem[cand_raddr];
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[i_r[AW-1:0]] <= wt_wdata;
    wt_rdata_r <= wt_mem[i_r[AW-1:0]];
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    nidx_nxt     = nidx_r;
    l_nxt        = l_r;
    id_nxt       = id_r;
    last_nxt     = last_r;
    draw_nxt     = draw_r;
    w_nxt        = w_r;
    full_nxt     = full_r;
    maxl_nxt     = maxl_r;
    k_nxt        = k_r;
    i_nxt        = i_r;
    sel_nxt      = sel_r;
    sum_nxt      = sum_r;
    cum_nxt      = cum_r;
    pthr_nxt     = pthr_r;
    tgt_nxt      = tgt_r;
    res_tok_nxt  = res_tok_r;
    res_kept_nxt = res_kept_r;
    ov_nxt       = ov_r;
    out_tok_nxt  = out_tok_r;
    out_kept_nxt = out_kept_r;
    cand_we      = 1'b0;
    cand_waddr   = w_r;
    cand_wl      = l_r;
    cand_wid     = id_r;
    cand_raddr   = '0;
    wt_we        = 1'b0;
    wt_wdata     = exp_e;
    exp_start    = 1'b0;
    exp_n        = EXP_N_W'(diff[LOGIT_W-1:0]);
    div_start    = 1'b0;
    div_dvd      = {diff[LOGIT_W-1:0], 8'd0} + DVD_W'(temp_r >> 1);

    // result register drains independently of the sequencer
    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          l_nxt    = in_logit;
          id_nxt   = nidx_r;
          last_nxt = in_last;
          draw_nxt = in_draw;
          nidx_nxt = (nidx_r == ID_W'(MAX_VOCAB - 1)) ? '0 : nidx_r + 1'b1;
          if (cnt_r == '0) begin
            // empty list: store straight into slot zero
            cand_we    = 1'b1;
            cand_waddr = '0;
            cand_wl    = in_logit;
            cand_wid   = nidx_r;
            cnt_nxt    = CNT_W'(1);
            state_nxt  = in_last ? S_HEAD_RD : S_IDLE;
          end else if (cnt_r < CNT_W'(MAX_CAND)) begin
            w_nxt     = cnt_r[AW-1:0];
            full_nxt  = 1'b0;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_INS_RD;
          end else begin
            // full list: first test against the tail entry
            w_nxt     = AW'(MAX_CAND - 1);
            full_nxt  = 1'b1;
            state_nxt = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        cand_raddr = full_r ? w_r : w_r - 1'b1;
        state_nxt  = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (rd_logit_r >= l_r) begin
          // equal logits keep arrival order; full and not greater is dropped
          if (!full_r) cand_we = 1'b1;
          state_nxt = last_r ? S_HEAD_RD : S_IDLE;
        end else if (full_r) begin
          full_nxt  = 1'b0;
          state_nxt = S_INS_RD;
        end else begin
          cand_we   = 1'b1;
          cand_wl   = rd_logit_r;
          cand_wid  = rd_index_r;
          w_nxt     = w_r - 1'b1;
          state_nxt = (w_r == AW'(1)) ? S_INS_PUT : S_INS_RD;
        end
      end
      S_INS_PUT: begin
        cand_we   = 1'b1;
        state_nxt = last_r ? S_HEAD_RD : S_IDLE;
      end
      S_HEAD_RD: begin
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        maxl_nxt = rd_logit_r;
        if (temp_r == '0 || topk_r == TOPK_W'(1)) begin
          // greedy pick
          res_tok_nxt  = rd_index_r;
          res_kept_nxt = CNT_W'(1);
          state_nxt    = S_OUT;
        end else begin
          k_nxt     = (klim < KC_W'(cnt_r)) ? CNT_W'(klim) : cnt_r;
          i_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = S_U_RD;
        end
      end
      S_U_RD: begin
        cand_raddr = i_r[AW-1:0];
        state_nxt  = S_U_EXP;
      end
      S_U_EXP: begin
        exp_start = 1'b1;
        state_nxt = S_U_WAIT;
      end
      S_U_WAIT: begin
        if (exp_valid) begin
          wt_we   = 1'b1;
          sum_nxt = sum_r + SUM_W'(exp_e);
          if (i_r + 1'b1 == k_r) begin
            state_nxt = S_P_INIT;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_U_RD;
          end
        end
      end
      S_P_INIT: begin
        if (topp_r[TOPP_W-1]) begin
          state_nxt = S_M_INIT;
        end else begin
          pthr_nxt  = PT_W'(topp_r) * PT_W'(sum_r);
          i_nxt     = '0;
          cum_nxt   = '0;
          state_nxt = S_P_RD;
        end
      end
      S_P_RD: begin
        state_nxt = S_P_CHK;
      end
      S_P_CHK: begin
        // smallest prefix whose mass reaches the nucleus threshold
        if ({cumn, 16'd0} >= PT_W'({pthr_r})) begin
          k_nxt     = i_r + 1'b1;
          state_nxt = S_M_INIT;
        end else if (i_r + 1'b1 == k_r) begin
          state_nxt = S_M_INIT;
        end else begin
          i_nxt     = i_r + 1'b1;
          cum_nxt   = cumn;
          state_nxt = S_P_RD;
        end
      end
      S_M_INIT: begin
        if (minp_r == '0 || k_r == CNT_W'(1)) begin
          state_nxt = S_W_INIT;
        end else begin
          i_nxt     = CNT_W'(1);
          state_nxt = S_M_RD;
        end
      end
      S_M_RD: begin
        state_nxt = S_M_CHK;
      end
      S_M_CHK: begin
        if (wt_rdata_r >= EXP_W'(minp_r)) begin
          if (i_r + 1'b1 == k_r) begin
            state_nxt = S_W_INIT;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_M_RD;
          end
        end else begin
          k_nxt     = i_r;
          state_nxt = S_W_INIT;
        end
      end
      S_W_INIT: begin
        i_nxt     = '0;
        sum_nxt   = '0;
        state_nxt = S_W_RD;
      end
      S_W_RD: begin
        cand_raddr = i_r[AW-1:0];
        state_nxt  = S_W_DIV;
      end
      S_W_DIV: begin
        div_start = 1'b1;
        state_nxt = S_W_DWAIT;
      end
      S_W_DWAIT: begin
        if (div_done) begin
          exp_start = 1'b1;
          exp_n     = div_quo;
          state_nxt = S_W_EWAIT;
        end
      end
      S_W_EWAIT: begin
        if (exp_valid) begin
          wt_we   = 1'b1;
          sum_nxt = sum_r + SUM_W'(exp_e);
          if (i_r + 1'b1 == k_r) begin
            state_nxt = S_D_INIT;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_W_RD;
          end
        end
      end
      S_D_INIT: begin
        tgt_nxt   = tprod[DRAW_W +: SUM_W];
        i_nxt     = '0;
        cum_nxt   = '0;
        state_nxt = S_D_RD;
      end
      S_D_RD: begin
        state_nxt = S_D_CHK;
      end
      S_D_CHK: begin
        // inverse cdf walk, last kept entry as fallback
        if (cumn > tgt_r || i_r + 1'b1 == k_r) begin
          sel_nxt   = i_r[AW-1:0];
          state_nxt = S_SEL_RD;
        end else begin
          i_nxt     = i_r + 1'b1;
          cum_nxt   = cumn;
          state_nxt = S_D_RD;
        end
      end
      S_SEL_RD: begin
        cand_raddr = sel_r;
        state_nxt  = S_SEL;
      end
      S_SEL: begin
        res_tok_nxt  = rd_index_r;
        res_kept_nxt = k_r;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        // wait for the previous result to leave, then start a new vector
        if (!ov_r) begin
          ov_nxt       = 1'b1;
          out_tok_nxt  = res_tok_r;
          out_kept_nxt = res_kept_r;
          cnt_nxt      = '0;
          nidx_nxt     = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    l_r        <= l_nxt;
    id_r       <= id_nxt;
    last_r     <= last_nxt;
    draw_r     <= draw_nxt;
    w_r        <= w_nxt;
    full_r     <= full_nxt;
    maxl_r     <= maxl_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    sel_r      <= sel_nxt;
    sum_r      <= sum_nxt;
    cum_r      <= cum_nxt;
    pthr_r     <= pthr_nxt;
    tgt_r      <= tgt_nxt;
    res_tok_r  <= res_tok_nxt;
    res_kept_r <= res_kept_nxt;
    out_tok_r  <= out_tok_nxt;
    out_kept_r <= out_kept_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      nidx_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      nidx_r  <= nidx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // list never grows past its capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CAND))
    else $error("candidate count above capacity");

  // issuing a result clears the list and the id counter
  a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !ov_r) |=> (ov_r && cnt_r == '0 && nidx_r == '0))
    else $error("result issued without clearing the list");

  // a shown result keeps at least one and at most all candidates
  a_kept_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (out_kept_r != '0 && out_kept_r <= CNT_W'(MAX_CAND)))
    else $error("kept count out of range");

  // exp results only arrive while the sequencer waits for them
  a_exp_owner: assert property (@(posedge clk) disable iff (!rst_n)
    exp_valid |-> (state_r == S_U_WAIT || state_r == S_W_EWAIT))
    else $error("stray exp result");

endmodule
